/* rtl/pchr_pkg.sv */
// ----------------------------------------------------------------------------
// pchr_pkg
// Shared types, constants and helpers for the pulse count hex reporter.
// ----------------------------------------------------------------------------
package pchr_pkg;

	localparam int unsigned MSG_LEN   = 11;
	localparam int unsigned IDX_W     = 4;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MSG_LEN - 1);

	localparam logic [7:0] REPORT_INTERVAL_RST = 8'd7;
	localparam logic [7:0] COMMAND_CHAR_RST    = 8'd68;  // 'D'

	localparam logic [7:0] ASCII_ZERO   = 8'h30;  // '0'
	localparam logic [7:0] ASCII_A_BIAS = 8'h37;  // 'A' - 10

	localparam int unsigned CFG_IDX_W = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_REPORT_INTERVAL = 8'd0,
		CFG_COMMAND_CHAR    = 8'd1
	} cfg_idx_t;

	typedef enum logic {
		ACT_COUNT = 1'b0,
		ACT_TICK  = 1'b1
	} action_t;

	typedef struct packed {
		logic       action;
		logic       first_level;
		logic       second_level;
		logic       associated;
		logic [9:0] battery_level;
	} sample_t;

	typedef struct packed {
		logic [7:0] char_out;
		logic       last;
	} report_t;

	// One report to be sent: the datum and the leading command character.
	typedef struct packed {
		logic        load;
		logic [31:0] datum;
		logic [7:0]  command_char;
	} msg_t;

	// Uppercase hex character for one nibble.
	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		if (nib < 4'd10) begin
			return ASCII_ZERO + {4'h0, nib};
		end else begin
			return ASCII_A_BIAS + {4'h0, nib};
		end
	endfunction

endpackage

/* rtl/pchr_tx.sv */
// ----------------------------------------------------------------------------
// pchr_tx
// Report serialiser: holds one message and sends its eleven characters.
// ----------------------------------------------------------------------------
module pchr_tx (
	input  logic             clk,
	input  logic             arst_n,
	input  pchr_pkg::msg_t   msg,
	output logic             free,
	output logic             report_valid,
	input  logic             report_stall,
	output pchr_pkg::report_t report
);

	logic                        busy_q;
	logic [pchr_pkg::IDX_W-1:0]  idx_q;
	logic [31:0]                 datum_q;
	logic [7:0]                  cmd_q;
	logic [7:0]                  byte_sum;
	logic [7:0]                  cks;
	logic [3:0]                  nib;
	logic                        beat;
	logic                        at_last;

	assign beat    = busy_q && !report_stall;
	assign at_last = (idx_q == pchr_pkg::LAST_IDX);
	assign free    = !busy_q || (beat && at_last);

	// Checksum: negated byte sum of the datum.
	assign byte_sum = datum_q[7:0] + datum_q[15:8] + datum_q[23:16] + datum_q[31:24];
	assign cks      = 8'd0 - byte_sum;

	always_comb begin
		case (idx_q)
			4'd1:    nib = cks[7:4];
			4'd2:    nib = cks[3:0];
			4'd3:    nib = datum_q[31:28];
			4'd4:    nib = datum_q[27:24];
			4'd5:    nib = datum_q[23:20];
			4'd6:    nib = datum_q[19:16];
			4'd7:    nib = datum_q[15:12];
			4'd8:    nib = datum_q[11:8];
			4'd9:    nib = datum_q[7:4];
			4'd10:   nib = datum_q[3:0];
			default: nib = 4'h0;
		endcase
	end

	always_comb begin
		report.char_out = (idx_q == '0) ? cmd_q : pchr_pkg::hex_char(nib);
		report.last     = at_last;
	end

	assign report_valid = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (msg.load && free) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (beat) begin
			// advance; the final beat drops busy
			if (at_last) begin
				busy_q <= 1'b0;
				idx_q  <= '0;
			end else begin
				idx_q <= idx_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (msg.load && free) begin
			datum_q <= msg.datum;
			cmd_q   <= msg.command_char;
		end
	end

endmodule

/* rtl/pulse_count_hex_reporter.sv */
// ----------------------------------------------------------------------------
// pulse_count_hex_reporter
// Pulse counter with a periodic eleven-character hexadecimal report.
// ----------------------------------------------------------------------------
// Usage:
//   sample channel (sample_valid / sample_stall / sample): one beat per
//   count event or watchdog tick. A beat is taken whenever stall is low.
//   report channel (report_valid / report_stall / report): one beat per
//   character; a report is eleven beats, the last one flagged.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): register
//   writes, always ready; write only while the block is idle.
// Timing:
//   A sample is registered, then processed from the input register, where
//   a reporting tick is held while the serialiser is busy. A report it
//   triggers shows its first character in the cycle after the serialiser loads it.
//   Samples are taken one per cycle while sample_stall is low. A report holds
//   the serialiser to its last beat; a further reporting tick waits in the
//   input register meanwhile, and count events behind it wait too.
// Reset: pulse and tick counts clear, interval returns to 7, command to 'D'.
// A stall on the report channel freezes the current character.
// ----------------------------------------------------------------------------
module pulse_count_hex_reporter (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              sample_valid,
	output logic                              sample_stall,
	input  pchr_pkg::sample_t                 sample,
	output logic                              report_valid,
	input  logic                              report_stall,
	output pchr_pkg::report_t                 report,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [pchr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [7:0]                        cfg_data
);

	// configuration registers
	logic [7:0] interval_q;
	logic [7:0] command_q;

	// input register
	logic              valid_s1;
	pchr_pkg::sample_t sample_s1;

	// counting state
	logic [31:0] pulse_q;
	logic [7:0]  tick_q;

	logic [7:0]     tick_next;
	logic           is_tick;
	logic           exceed;
	logic           wants_report;
	logic           advance;
	logic           tx_free;
	pchr_pkg::msg_t msg;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= pchr_pkg::REPORT_INTERVAL_RST;
			command_q  <= pchr_pkg::COMMAND_CHAR_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				pchr_pkg::CFG_REPORT_INTERVAL: interval_q <= cfg_data;
				pchr_pkg::CFG_COMMAND_CHAR:    command_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Decode the held sample. A tick that passes the interval while
	// associated needs the serialiser; hold it until that is free.
	assign is_tick      = (sample_s1.action == pchr_pkg::ACT_TICK);
	assign tick_next    = tick_q + 8'd1;
	assign exceed       = (tick_next > interval_q);
	assign wants_report = is_tick && exceed && sample_s1.associated;
	assign advance      = valid_s1 && (!wants_report || tx_free);
	assign sample_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!sample_stall) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!sample_stall) begin
			sample_s1 <= sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_q <= '0;
			tick_q  <= '0;
		end else if (advance) begin
			if (!is_tick) begin
				// count only when both level samples are high
				if (sample_s1.first_level && sample_s1.second_level) begin
					pulse_q <= pulse_q + 32'd1;
				end
			end else if (exceed) begin
				tick_q <= '0;
				if (sample_s1.associated) begin
					pulse_q <= '0;
				end
			end else begin
				tick_q <= tick_next;
			end
		end
	end

	always_comb begin
		msg.load         = valid_s1 && wants_report;
		msg.datum        = pulse_q + {6'd0, sample_s1.battery_level, 16'd0};
		msg.command_char = command_q;
	end

	pchr_tx u_tx (
		.clk          (clk),
		.arst_n       (arst_n),
		.msg          (msg),
		.free         (tx_free),
		.report_valid (report_valid),
		.report_stall (report_stall),
		.report       (report)
	);

endmodule

/* tb/pchr_tb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pchr_tb_pkg
// Report scoreboard: mirrors the pulse and tick counters from accepted
// sample beats and checks each report beat against the oldest due character.
// ----------------------------------------------------------------------------
package pchr_tb_pkg;

	import pchr_pkg::*;

	class report_scoreboard;

		logic [7:0]  interval;
		logic [7:0]  command;
		logic [31:0] pulses;
		logic [7:0]  ticks;
		report_t     due_chars[$];
		int unsigned mismatches;
		string       digits;

		function new();
			interval     = REPORT_INTERVAL_RST;
			command      = COMMAND_CHAR_RST;
			pulses       = '0;
			ticks        = '0;
			mismatches   = 0;
			digits       = "0123456789ABCDEF";
		endfunction

		function void write_reg(cfg_idx_t idx, logic [7:0] value);
			case (idx)
				CFG_REPORT_INTERVAL: interval = value;
				CFG_COMMAND_CHAR:    command  = value;
				default: ;
			endcase
		endfunction

		// Advance the counters for one sample beat; queue a report if one is due.
		function void note_sample(sample_t s);
			logic [31:0] datum;
			logic [7:0]  cks;
			logic [7:0]  text [MSG_LEN];
			report_t     r;
			if (s.action == ACT_COUNT) begin
				if (s.first_level && s.second_level) begin
					pulses = pulses + 32'd1;
				end
				return;
			end
			ticks = ticks + 8'd1;
			if (ticks <= interval) begin
				return;
			end
			ticks = '0;
			if (!s.associated) begin
				return;
			end
			datum = pulses + {6'b0, s.battery_level, 16'b0};
			cks   = 8'd0 - (datum[7:0] + datum[15:8] + datum[23:16] + datum[31:24]);
			text[0] = command;
			text[1] = digits[cks[7:4]];
			text[2] = digits[cks[3:0]];
			for (int k = 0; k < 8; k++) begin
				text[3 + k] = digits[datum[31 - 4 * k -: 4]];
			end
			for (int k = 0; k < MSG_LEN; k++) begin
				r.char_out = text[k];
				r.last     = (k == MSG_LEN - 1);
				due_chars.push_back(r);
			end
			pulses = '0;
		endfunction

		function void flag(string what);
			mismatches++;
			if (mismatches <= 10) begin
				$display("[%0t] mismatch: %s", $time, what);
			end
		endfunction

		function void check_report(report_t got);
			report_t want;
			if (due_chars.size() == 0) begin
				flag($sformatf("report beat with nothing due, char %02h last %b",
					got.char_out, got.last));
				return;
			end
			want = due_chars.pop_front();
			if (got.char_out !== want.char_out) begin
				flag($sformatf("char_out expected %02h got %02h", want.char_out, got.char_out));
			end
			if (got.last !== want.last) begin
				flag($sformatf("last expected %b got %b (char %02h)",
					want.last, got.last, want.char_out));
			end
		endfunction

	endclass

endpackage

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pulse count hex reporter. Drives count events
// and watchdog ticks, predicts every report character and compares it beat by
// beat, under several register settings and idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_top;

	import pchr_pkg::*;
	import pchr_tb_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 200000;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned RANDOM_BEATS  = 29;

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 sample_valid = 1'b0;
	logic                 sample_stall;
	sample_t              sample       = '0;
	logic                 report_valid;
	logic                 report_stall = 1'b0;
	report_t              report;
	logic                 cfg_valid    = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index    = '0;
	logic [7:0]           cfg_data     = '0;

	// Chance, in percent, that the sender idles before a beat and that the
	// receiver stalls in a given cycle.
	int unsigned send_idle_pct  = 38;
	int unsigned recv_stall_pct = 55;
	int unsigned cycles         = 0;

	report_scoreboard report_sb = new();

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	pulse_count_hex_reporter dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.report_valid (report_valid),
		.report_stall (report_stall),
		.report       (report),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// Report side: values read here are those settled before the edge, so a
	// beat is taken exactly when valid was high and our stall was low.
	always @(posedge clk) begin
		if (arst_n && report_valid && !report_stall) begin
			report_sb.check_report(report);
		end
		report_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	// Guard against a hung block or a lost report.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	function automatic sample_t pack_sample(action_t act, logic first, logic second,
		logic assoc, logic [9:0] battery);
		sample_t s;
		s.action        = act;
		s.first_level   = first;
		s.second_level  = second;
		s.associated    = assoc;
		s.battery_level = battery;
		return s;
	endfunction

	// Mostly well-formed traffic: levels lean high so pulses accumulate, most
	// ticks are associated; battery often sits at its extremes.
	function automatic sample_t random_sample();
		sample_t s;
		s.action       = ($urandom_range(0, 99) < 45) ? ACT_TICK : ACT_COUNT;
		s.first_level  = ($urandom_range(0, 3) != 0);
		s.second_level = ($urandom_range(0, 3) != 0);
		s.associated   = ($urandom_range(0, 4) != 0);
		case ($urandom_range(0, 7))
			0:       s.battery_level = '0;
			1:       s.battery_level = '1;
			default: s.battery_level = 10'($urandom_range(0, 1023));
		endcase
		return s;
	endfunction

	// Offer one sample beat, idling first at random. Valid stays high after
	// acceptance so back-to-back beats need no drop in between.
	task automatic send_sample(input sample_t s);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			sample       <= random_sample();
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		sample       <= s;
		@(posedge clk);
		while (sample_stall) begin
			@(posedge clk);
		end
		report_sb.note_sample(s);
	endtask

	// Hold the sender until every due character has arrived, then let any
	// queued count events drain through the input register.
	task automatic settle();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (report_sb.due_chars.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write both registers back to back; only call while the block is idle.
	task automatic program_regs(input logic [7:0] interval, input logic [7:0] cmd);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_REPORT_INTERVAL;
		cfg_data  <= interval;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		report_sb.write_reg(CFG_REPORT_INTERVAL, interval);
		cfg_index <= CFG_COMMAND_CHAR;
		cfg_data  <= cmd;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		report_sb.write_reg(CFG_COMMAND_CHAR, cmd);
		cfg_valid <= 1'b0;
	endtask

	// One random phase: fresh settings, then a burst of random beats with the
	// odd pause until the reports have drained.
	task automatic random_phase(input int unsigned beats);
		logic [7:0] interval;
		logic [7:0] cmd;
		case ($urandom_range(0, 5))
			0:       interval = 8'd0;
			1:       interval = 8'($urandom_range(7, 24));
			default: interval = 8'($urandom_range(1, 6));
		endcase
		case ($urandom_range(0, 5))
			0:       cmd = 8'h00;
			1:       cmd = 8'hFF;
			default: cmd = 8'($urandom_range(0, 255));
		endcase
		settle();
		program_regs(interval, cmd);
		repeat (beats) begin
			send_sample(random_sample());
			if ($urandom_range(0, 29) == 0) begin
				settle();
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings (interval 7, 'D'). Every level pair on count events;
		// only the two high-high ones count, association and battery ignored.
		send_sample(pack_sample(ACT_COUNT, 1'b0, 1'b0, 1'b1, '1));
		send_sample(pack_sample(ACT_COUNT, 1'b1, 1'b0, 1'b0, '0));
		send_sample(pack_sample(ACT_COUNT, 1'b0, 1'b1, 1'b1, 10'h2AA));
		send_sample(pack_sample(ACT_COUNT, 1'b1, 1'b1, 1'b0, 10'h155));
		send_sample(pack_sample(ACT_COUNT, 1'b1, 1'b1, 1'b1, '1));
		// Ticks short of the interval: nothing comes out.
		repeat (7) send_sample(pack_sample(ACT_TICK, 1'b0, 1'b0, 1'b1, 10'h3C3));
		// Interval passed while not associated: tick count clears, pulses kept.
		send_sample(pack_sample(ACT_TICK, 1'b1, 1'b1, 1'b0, '1));
		// Next round reports the kept pulses with a full-scale battery reading.
		repeat (7) send_sample(pack_sample(ACT_TICK, 1'b0, 1'b1, 1'b0, '0));
		send_sample(pack_sample(ACT_TICK, 1'b1, 1'b0, 1'b1, '1));

		// Interval 0 reports on every tick; a zero datum and a NUL command.
		settle();
		program_regs(8'd0, 8'h00);
		send_sample(pack_sample(ACT_TICK, 1'b0, 1'b0, 1'b1, '0));
		send_sample(pack_sample(ACT_COUNT, 1'b1, 1'b1, 1'b0, '0));
		send_sample(pack_sample(ACT_TICK, 1'b1, 1'b1, 1'b1, 10'h155));

		// Interval 255: the tick count can never pass it, so stay silent.
		settle();
		program_regs(8'd255, 8'($urandom_range(0, 255)));
		repeat (12) send_sample(pack_sample(ACT_TICK, 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 10'($urandom_range(0, 1023))));

		// Random traffic: sender-light idling first, then receiver-light, then none.
		repeat (2) random_phase(RANDOM_BEATS);
		send_idle_pct  = 55;
		recv_stall_pct = 38;
		repeat (2) random_phase(RANDOM_BEATS);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		repeat (2) random_phase(RANDOM_BEATS);

		settle();
		if (report_sb.mismatches == 0 && report_sb.due_chars.size() == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule

/* files.f */
rtl/pchr_pkg.sv
rtl/pchr_tx.sv
rtl/pulse_count_hex_reporter.sv
tb/pchr_tb_pkg.sv
tb/tb_top.sv
